// ===== hdl/luhn_check_digit_unit_defines.svh =====
// Assertion macros for the Luhn check digit unit.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef LUHN_CHECK_DIGIT_UNIT_DEFINES_SVH
`define LUHN_CHECK_DIGIT_UNIT_DEFINES_SVH

// Same-cycle implication
`define LCDU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcdu: same-cycle check failed");

// Next-cycle implication
`define LCDU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcdu: next-cycle check failed");

`endif

// ===== hdl/lcdu_pkg.sv =====
package lcdu_pkg;

  // Default number of decimal digits protected by one check digit
  localparam int unsigned DefaultDigits = 8;

  // Double dabble shift steps folded into one register stage
  localparam int unsigned DabbleStepsPerStage = 8;

  // Width of a Luhn digit sum (nine digits of at most 9 each)
  localparam int unsigned SumWidth = 7;

  // Reciprocal of ten for a 32-bit dividend, used with a shift of 35
  localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  localparam logic [31:0] AllOnes = '1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_VERIFY = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  // 10**n, evaluated at elaboration only
  function automatic longint unsigned pow10(int unsigned n);
    longint unsigned p;
    p = 1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Doubled digit with its two digits summed
  function automatic logic [3:0] luhn_double(logic [3:0] d);
    logic [4:0] two_d;
    two_d = {d, 1'b0};
    if (two_d > 5'd9) begin
      two_d = two_d - 5'd9;
    end
    return two_d[3:0];
  endfunction

  // Remainder by ten of a digit sum, by conditional subtraction
  function automatic logic [3:0] mod10_sum(logic [SumWidth-1:0] s);
    logic [SumWidth-1:0] r;
    r = s;
    if (r >= 7'd80) r = r - 7'd80;
    if (r >= 7'd40) r = r - 7'd40;
    if (r >= 7'd20) r = r - 7'd20;
    if (r >= 7'd10) r = r - 7'd10;
    return r[3:0];
  endfunction

  // Check digit: (sum * 9) mod 10, i.e. the tens complement of sum mod 10
  function automatic logic [3:0] check_digit(logic [SumWidth-1:0] s);
    logic [3:0] m;
    m = mod10_sum(s);
    return (m == 4'd0) ? 4'd0 : 4'd10 - m;
  endfunction

endpackage

// ===== hdl/lcdu_in_if.sv =====
// Command channel: one command and one number per transfer
interface lcdu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== hdl/lcdu_out_if.sv =====
// Result channel: one result per command
interface lcdu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        check_ok;
  logic        error;

  modport source (output valid, output result, output check_ok, output error, input ready);
  modport sink   (input valid, input result, input check_ok, input error, output ready);
endinterface

// ===== hdl/luhn_check_digit_unit.sv =====
// Stages: quotient, select and range check, binary to BCD conversion, Luhn sum, output; the
//   binary to BCD conversion, 8 shift steps per stage, sets how many conversion stages there are.
// Throughput: one item per cycle; stalls back up stage by stage and bubbles are squeezed out.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only; no clearing pass.
`include "luhn_check_digit_unit_defines.svh"
module luhn_check_digit_unit #(
  parameter int unsigned DIGITS = lcdu_pkg::DefaultDigits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcdu_in_if.sink    in_i,
  lcdu_out_if.source out_o
);

  localparam logic [31:0] MaxVal = 32'(lcdu_pkg::pow10(DIGITS) - 1);
  localparam int unsigned XW     = $clog2(lcdu_pkg::pow10(DIGITS));
  localparam int unsigned BW     = 4 * DIGITS;
  localparam int unsigned SW     = BW + XW;
  localparam int unsigned SPS    = lcdu_pkg::DabbleStepsPerStage;
  localparam int unsigned NS     = (XW + SPS - 1) / SPS;
  localparam int unsigned NST    = NS + 4;
  localparam int unsigned LAST   = NST - 1;
  localparam int unsigned SUMW   = lcdu_pkg::SumWidth;

  // Payload that rides beside the conversion
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  rem;       // last decimal digit of the input
    logic        in_range;  // converted number has at most DIGITS digits
    logic [35:0] base;      // add: value*10, verify/remove: value/10
  } side_t;

  // Run the double dabble steps that fall into one stage
  function automatic logic [SW-1:0] dabble_run(logic [SW-1:0] sr_in, int unsigned first);
    logic [SW-1:0] sr;
    sr = sr_in;
    for (int unsigned i = 0; i < SPS; i++) begin
      if (first + i < XW) begin
        for (int unsigned k = 0; k < DIGITS; k++) begin
          if (sr[XW + 4*k +: 4] >= 4'd5) begin
            sr[XW + 4*k +: 4] = sr[XW + 4*k +: 4] + 4'd3;
          end
        end
        sr = {sr[SW-2:0], 1'b0};
      end
    end
    return sr;
  endfunction

  // Stage flow control: a stage loads when empty or when its successor loads
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;

  always_comb begin
    en[LAST] = !vld_q[LAST] || out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 1: quotient by ten through the reciprocal multiply
  logic [63:0] s1_prod;
  logic [1:0]  s1_cmd_q;
  logic [31:0] s1_val_q;
  logic [28:0] s1_quo_q;

  assign s1_prod = 64'(in_i.value) * 64'(lcdu_pkg::RecipTen);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_cmd_q <= in_i.cmd;
      s1_val_q <= in_i.value;
      s1_quo_q <= s1_prod[63:lcdu_pkg::RecipShift];
    end
  end

  // Stage 2: pick the number to convert, range check, last digit, value*10
  logic [31:0]   s2_x;
  logic [6:0]    s2_quo_ten;
  logic [35:0]   s2_times10;
  side_t         s2_side_d, s2_side_q;
  logic [SW-1:0] s2_sr_q;

  always_comb begin
    s2_x = (s1_cmd_q == lcdu_pkg::CMD_ADD) ? s1_val_q : {3'b0, s1_quo_q};
    s2_quo_ten = 7'({s1_quo_q[3:0], 3'b0}) + 7'({s1_quo_q[3:0], 1'b0});
    s2_times10 = {1'b0, s1_val_q, 3'b0} + {3'b0, s1_val_q, 1'b0};
    s2_side_d.cmd      = s1_cmd_q;
    s2_side_d.rem      = s1_val_q[3:0] - s2_quo_ten[3:0];
    s2_side_d.in_range = (s2_x <= MaxVal);
    s2_side_d.base     = (s1_cmd_q == lcdu_pkg::CMD_ADD) ? s2_times10 : {7'b0, s1_quo_q};
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_side_q <= s2_side_d;
      s2_sr_q   <= {{BW{1'b0}}, s2_x[XW-1:0]};
    end
  end

  // Binary to BCD conversion, SPS shift steps per stage
  logic [SW-1:0] dd_sr_d  [NS];
  logic [SW-1:0] dd_sr_q  [NS];
  side_t         dd_side_q[NS];

  always_comb begin
    dd_sr_d[0] = dabble_run(s2_sr_q, 0);
    for (int unsigned j = 1; j < NS; j++) begin
      dd_sr_d[j] = dabble_run(dd_sr_q[j-1], j * SPS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dd_sr_q[0]   <= dd_sr_d[0];
      dd_side_q[0] <= s2_side_q;
    end
    for (int unsigned j = 1; j < NS; j++) begin
      if (en[2+j]) begin
        dd_sr_q[j]   <= dd_sr_d[j];
        dd_side_q[j] <= dd_side_q[j-1];
      end
    end
  end

  // Luhn sum: even positions from the right are doubled
  logic [BW-1:0]   sm_bcd;
  logic [SUMW-1:0] sm_sum_d, sm_sum_q;
  side_t           sm_side_q;

  assign sm_bcd = dd_sr_q[NS-1][SW-1 -: BW];

  always_comb begin
    sm_sum_d = '0;
    for (int unsigned k = 0; k < DIGITS; k++) begin
      if (k % 2 == 0) begin
        sm_sum_d = sm_sum_d + SUMW'(lcdu_pkg::luhn_double(sm_bcd[4*k +: 4]));
      end else begin
        sm_sum_d = sm_sum_d + SUMW'(sm_bcd[4*k +: 4]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS+2]) begin
      sm_sum_q  <= sm_sum_d;
      sm_side_q <= dd_side_q[NS-1];
    end
  end

  // Output stage: check digit, command decode, result register
  logic [3:0]  ot_chk;
  logic [35:0] ot_added;
  logic        ot_match;
  logic [31:0] ot_result_d, ot_result_q;
  logic        ot_ok_d, ot_ok_q;
  logic        ot_err_d, ot_err_q;

  always_comb begin
    ot_chk      = lcdu_pkg::check_digit(sm_sum_q);
    ot_added    = sm_side_q.base + 36'(ot_chk);
    ot_match    = sm_side_q.in_range && (ot_chk == sm_side_q.rem);
    ot_result_d = lcdu_pkg::AllOnes;
    ot_ok_d     = 1'b0;
    ot_err_d    = 1'b1;
    unique case (lcdu_pkg::cmd_e'(sm_side_q.cmd))
      lcdu_pkg::CMD_ADD: begin
        if (sm_side_q.in_range && (ot_added[35:32] == 4'd0)) begin
          ot_result_d = ot_added[31:0];
          ot_err_d    = 1'b0;
        end
      end
      lcdu_pkg::CMD_VERIFY: begin
        ot_result_d = '0;
        ot_ok_d     = ot_match;
        ot_err_d    = !ot_match;
      end
      lcdu_pkg::CMD_REMOVE: begin
        if (ot_match) begin
          ot_result_d = sm_side_q.base[31:0];
          ot_ok_d     = 1'b1;
          ot_err_d    = 1'b0;
        end
      end
      default: begin
        ot_result_d = lcdu_pkg::AllOnes;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      ot_result_q <= ot_result_d;
      ot_ok_q     <= ot_ok_d;
      ot_err_q    <= ot_err_d;
    end
  end

  assign out_o.valid    = vld_q[LAST];
  assign out_o.result   = ot_result_q;
  assign out_o.check_ok = ot_ok_q;
  assign out_o.error    = ot_err_q;

  // Checks
  `LCDU_ASSERT_IMP(a_ok_err_exclusive, out_o.valid, !(out_o.check_ok && out_o.error))
  `LCDU_ASSERT_IMP(a_ready_when_out_free, !vld_q[LAST], in_i.ready)
  `LCDU_ASSERT_NXT(a_transfer_enters, in_i.valid && in_i.ready, vld_q[0])

endmodule
